>>> rtl/st_pkg.sv
// types and constants shared by the source tokenizer modules
package st_pkg;

	localparam int POS_W = 24;
	localparam int LINE_W = 20;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [3:0] {
		TK_EOF = 4'd0,
		TK_IDENT = 4'd1,
		TK_STRING = 4'd2,
		TK_LBRACE = 4'd3,
		TK_RBRACE = 4'd4,
		TK_EQUAL = 4'd5,
		TK_ARROW = 4'd6,
		TK_DARROW = 4'd7,
		TK_NEWLINE = 4'd8,
		TK_ERROR = 4'd9
	} tok_kind_t;

	localparam logic ERR_UNEXPECTED = 1'b0;
	localparam logic ERR_UNTERMINATED = 1'b1;

	typedef enum logic [3:0] {
		M_IDLE = 4'd0,
		M_IDENT = 4'd1,
		M_LT = 4'd2,
		M_LTDASH = 4'd3,
		M_DASH = 4'd4,
		M_SLASH = 4'd5,
		M_LCOMMENT = 4'd6,
		M_BLOCK = 4'd7,
		M_BLOCK_STAR = 4'd8,
		M_STR_DQ = 4'd9,
		M_STR_SQ = 4'd10
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic end_of_source;
	} char_req_t;

	typedef struct packed {
		tok_kind_t token_kind;
		logic error_code;
		logic [POS_W-1:0] start_position;
		logic [POS_W-1:0] token_length;
		logic [LINE_W-1:0] line_number;
		logic last_of_run;
	} tok_req_t;

	typedef struct packed {
		logic [1:0] cnt;
		tok_req_t first;
		tok_req_t second;
	} st_push_t;

endpackage

>>> rtl/source_tokenizer.sv
// source tokenizer top level: byte scanner feeding a token queue
//
// char channel: char_valid / char_stall / char_req carry one source byte, or an
// end-of-source request when char_req.end_of_source is set.
// tok channel: tok_valid / tok_stall / tok_req carry one token per request; the
// last token caused by one char request has last_of_run set.
// A char request's tokens are visible on tok_req the cycle after it is accepted
// when no older token waits, one token per cycle while tok_stall is low.
// The scanner accepts a
// char request every cycle while the four-entry token queue has room for two
// tokens; a byte that closes a pending token and is a one-byte token itself
// gives two, so a long run of such bytes is limited by the one-token-per-cycle
// output. char_stall follows the queue fill level only.
// Reset empties the token queue and sets the scanner to idle, position zero and
// line one. An end-of-source request emits any pending token and eof, then
// restores the same state for the next source.
// When the receiver holds tok_stall, tok_req holds and the queue fills; at three
// or more queued tokens char_stall rises until the receiver takes them.
module source_tokenizer #(
	parameter int POSITION_BITS = 24,
	parameter int LINE_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	input logic char_valid,
	output logic char_stall,
	input st_pkg::char_req_t char_req,
	output logic tok_valid,
	input logic tok_stall,
	output st_pkg::tok_req_t tok_req
);
	import st_pkg::*;

	st_push_t push;
	logic acc;
	logic full;

	assign char_stall = full;
	assign acc = char_valid && !char_stall;

	st_scan #(
		.POSITION_BITS(POSITION_BITS),
		.LINE_BITS(LINE_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.req(char_req),
		.push(push)
	);

	st_result_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_req(tok_req)
	);

`ifndef SYNTHESIS
	a_end_yields_token: assert property (@(posedge clk) disable iff (!arst_n)
		acc && char_req.end_of_source |=> tok_valid)
		else $error("end request produced no token");
`endif

endmodule

>>> rtl/st_scan.sv
// scan state registers and per-byte next-state and token logic
module st_scan #(
	parameter int POSITION_BITS = 24,
	parameter int LINE_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	input logic acc,
	input st_pkg::char_req_t req,
	output st_pkg::st_push_t push
);
	import st_pkg::*;

	localparam logic [7:0] C_LBRACE = 8'h7B;
	localparam logic [7:0] C_RBRACE = 8'h7D;
	localparam logic [7:0] C_EQUAL = 8'h3D;
	localparam logic [7:0] C_LT = 8'h3C;
	localparam logic [7:0] C_DASH = 8'h2D;
	localparam logic [7:0] C_GT = 8'h3E;
	localparam logic [7:0] C_SLASH = 8'h2F;
	localparam logic [7:0] C_STAR = 8'h2A;
	localparam logic [7:0] C_UNDER = 8'h5F;
	localparam logic [7:0] C_NL = 8'h0A;
	localparam logic [7:0] C_SQUOTE = 8'h27;
	localparam logic [7:0] C_DQUOTE = 8'h22;
	localparam logic [7:0] C_SPACE = 8'h20;
	localparam logic [7:0] C_TAB = 8'h09;
	localparam logic [7:0] C_CR = 8'h0D;

	function automatic logic is_word(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39) || c == C_UNDER;
	endfunction

	scan_mode_t mode_q, mode_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d, ts_q, ts_d;
	logic [LINE_BITS-1:0] line_q, line_d, line_b;

	logic [POSITION_BITS-1:0] span_p, span_p1, str_start, str_len;
	logic [7:0] c;
	logic rescan;
	logic a_v, b_v;
	tok_kind_t a_kind, b_kind;
	logic a_code, b_code;
	logic [POSITION_BITS-1:0] a_start, a_len, b_start, b_len;
	tok_req_t res_a, res_b;

	assign c = req.char_byte;
	assign span_p = pos_q - ts_q;
	assign span_p1 = pos_q + POSITION_BITS'(1) - ts_q;
	assign str_start = ts_q + POSITION_BITS'(1);
	assign str_len = span_p - POSITION_BITS'(1);

	always_comb begin
		mode_d = mode_q;
		ts_d = ts_q;
		line_d = line_q;
		pos_d = pos_q;
		rescan = 1'b0;
		a_v = 1'b0;
		a_kind = TK_ERROR;
		a_code = ERR_UNEXPECTED;
		a_start = ts_q;
		a_len = span_p;
		b_v = 1'b0;
		b_kind = TK_EOF;
		b_code = ERR_UNEXPECTED;
		b_start = pos_q;
		b_len = '0;
		if (req.end_of_source) begin
			unique case (mode_q)
				M_IDENT: begin
					a_v = 1'b1;
					a_kind = TK_IDENT;
				end
				M_LT, M_LTDASH, M_DASH, M_SLASH: begin
					a_v = 1'b1;
				end
				M_STR_DQ, M_STR_SQ: begin
					a_v = 1'b1;
					a_code = ERR_UNTERMINATED;
				end
				default: begin
				end
			endcase
			b_v = 1'b1;
			mode_d = M_IDLE;
			pos_d = '0;
			ts_d = '0;
			line_d = LINE_BITS'(1);
		end else begin
			pos_d = pos_q + POSITION_BITS'(1);
			unique case (mode_q)
				M_IDENT: begin
					if (!is_word(c)) begin
						a_v = 1'b1;
						a_kind = TK_IDENT;
						rescan = 1'b1;
					end
				end
				M_LT: begin
					if (c == C_DASH) begin
						mode_d = M_LTDASH;
					end else begin
						a_v = 1'b1;
						rescan = 1'b1;
					end
				end
				M_LTDASH, M_DASH: begin
					if (c == C_GT) begin
						a_v = 1'b1;
						a_kind = (mode_q == M_DASH) ? TK_ARROW : TK_DARROW;
						a_len = span_p1;
						mode_d = M_IDLE;
					end else begin
						a_v = 1'b1;
						rescan = 1'b1;
					end
				end
				M_SLASH: begin
					if (c == C_SLASH) begin
						mode_d = M_LCOMMENT;
					end else if (c == C_STAR) begin
						mode_d = M_BLOCK;
					end else begin
						a_v = 1'b1;
						rescan = 1'b1;
					end
				end
				M_LCOMMENT: begin
					if (c == C_NL) begin
						rescan = 1'b1;
					end
				end
				M_BLOCK: begin
					if (c == C_STAR) begin
						mode_d = M_BLOCK_STAR;
					end
				end
				M_BLOCK_STAR: begin
					if (c == C_SLASH) begin
						mode_d = M_IDLE;
					end else if (c != C_STAR) begin
						mode_d = M_BLOCK;
					end
				end
				M_STR_DQ, M_STR_SQ: begin
					if (c == ((mode_q == M_STR_DQ) ? C_DQUOTE : C_SQUOTE)) begin
						a_v = 1'b1;
						a_kind = TK_STRING;
						a_start = str_start;
						a_len = str_len;
						mode_d = M_IDLE;
					end else if (c == C_NL) begin
						a_v = 1'b1;
						a_code = ERR_UNTERMINATED;
						rescan = 1'b1;
					end
				end
				default: begin
					rescan = 1'b1;
				end
			endcase
			if (rescan) begin
				mode_d = M_IDLE;
				b_len = POSITION_BITS'(1);
				if (c == C_SPACE || c == C_TAB || c == C_CR) begin
				end else if (is_word(c)) begin
					ts_d = pos_q;
					mode_d = M_IDENT;
				end else begin
					unique case (c)
						C_LBRACE: begin
							b_v = 1'b1;
							b_kind = TK_LBRACE;
						end
						C_RBRACE: begin
							b_v = 1'b1;
							b_kind = TK_RBRACE;
						end
						C_EQUAL: begin
							b_v = 1'b1;
							b_kind = TK_EQUAL;
						end
						C_LT: begin
							ts_d = pos_q;
							mode_d = M_LT;
						end
						C_DASH: begin
							ts_d = pos_q;
							mode_d = M_DASH;
						end
						C_SLASH: begin
							ts_d = pos_q;
							mode_d = M_SLASH;
						end
						C_DQUOTE: begin
							ts_d = pos_q;
							mode_d = M_STR_DQ;
						end
						C_SQUOTE: begin
							ts_d = pos_q;
							mode_d = M_STR_SQ;
						end
						C_NL: begin
							b_v = 1'b1;
							b_kind = TK_NEWLINE;
							if (line_q != {LINE_BITS{1'b1}}) begin
								line_d = line_q + LINE_BITS'(1);
							end
						end
						default: begin
							b_v = 1'b1;
							b_kind = TK_ERROR;
						end
					endcase
				end
			end
		end
	end

	// eof reports the line before reset, a newline the updated one
	assign line_b = req.end_of_source ? line_q : line_d;

	always_comb begin
		res_a.token_kind = a_kind;
		res_a.error_code = (a_kind == TK_ERROR) ? a_code : ERR_UNEXPECTED;
		res_a.start_position = POS_W'(a_start);
		res_a.token_length = POS_W'(a_len);
		res_a.line_number = LINE_W'(line_q);
		res_a.last_of_run = ~b_v;
		res_b.token_kind = b_kind;
		res_b.error_code = ERR_UNEXPECTED;
		res_b.start_position = POS_W'(b_start);
		res_b.token_length = POS_W'(b_len);
		res_b.line_number = LINE_W'(line_b);
		res_b.last_of_run = 1'b1;
		push.first = a_v ? res_a : res_b;
		push.second = res_b;
		push.cnt = acc ? (2'(a_v) + 2'(b_v)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q <= '0;
			ts_q <= '0;
			line_q <= LINE_BITS'(1);
		end else if (acc) begin
			mode_q <= mode_d;
			pos_q <= pos_d;
			ts_q <= ts_d;
			line_q <= line_d;
		end
	end

`ifndef SYNTHESIS
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.end_of_source |=> mode_q == M_IDLE && line_q == LINE_BITS'(1)
			&& pos_q == '0)
		else $error("end request did not restore scan state");
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line count reached zero");
	a_end_gives_eof: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.end_of_source |-> push.cnt != 2'd0
			&& (push.cnt == 2'd2 ? push.second.token_kind : push.first.token_kind) == TK_EOF)
		else $error("end request without eof token");
`endif

endmodule

>>> rtl/st_result_fifo.sv
// four-entry token queue taking up to two tokens per cycle
module st_result_fifo (
	input logic clk,
	input logic arst_n,
	input st_pkg::st_push_t push,
	output logic full,
	output logic tok_valid,
	input logic tok_stall,
	output st_pkg::tok_req_t tok_req
);
	import st_pkg::*;

	tok_req_t fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic pop;

	assign pop = tok_valid && !tok_stall;
	assign tok_valid = count_q != '0;
	assign tok_req = fifo_q[rd_ptr_q];
	assign full = count_q > FIFO_CW'(FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			fifo_q[wr_ptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			fifo_q[wr_ptr_q + FIFO_AW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.cnt);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			count_q <= count_q + FIFO_CW'(push.cnt) - FIFO_CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("token queue overflow");
	a_pop_moves_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rd_ptr_q == $past(rd_ptr_q) + FIFO_AW'(1))
		else $error("read pointer did not advance");
`endif

endmodule
